// ----- sv/rotated_curl_edge_projection_assert.svh -----
// Assertion macros for the edge projection block.
`ifndef ROTATED_CURL_EDGE_PROJECTION_ASSERT_SVH
`define ROTATED_CURL_EDGE_PROJECTION_ASSERT_SVH
// Checks that a condition implies a consequence in the same cycle.
`define RCEP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
// Checks that a condition implies a consequence in the next cycle.
`define RCEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`endif

// ----- sv/rcep_pkg.sv -----
package rcep_pkg;

    localparam int EdgeCount = 1024;
    localparam int IdxW = 10;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_PROJ = 2'd1,
        MODE_DMU  = 2'd2,
        MODE_DTH  = 2'd3
    } mode_t;

    localparam logic [2:0] REG_MU    = 3'd0;
    localparam logic [2:0] REG_THETA = 3'd1;
    localparam logic [2:0] REG_CX    = 3'd2;
    localparam logic [2:0] REG_CY    = 3'd3;
    localparam logic [2:0] REG_CZ    = 3'd4;
    localparam logic [2:0] REG_AX    = 3'd5;
    localparam logic [2:0] REG_AY    = 3'd6;
    localparam logic [2:0] REG_AZ    = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         edge_index;
        logic signed [31:0] first_node_x;
        logic signed [31:0] first_node_y;
        logic signed [31:0] first_node_z;
        logic signed [31:0] second_node_x;
        logic signed [31:0] second_node_y;
        logic signed [31:0] second_node_z;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] projection_value;
        logic               saturated;
    } out_word_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       capture;
        logic       load_step;
        logic       cordic_init;
        logic       cordic_step;
        logic       rod_step;
        logic       query_step;
        logic [4:0] count;
    } ctl_t;

    typedef struct packed {
        logic [1:0] mode;
    } stat_t;

    function automatic logic signed [17:0] atan_q16(input logic [3:0] i);
        case (i)
            4'd0:    atan_q16 = 18'sd51472;
            4'd1:    atan_q16 = 18'sd30386;
            4'd2:    atan_q16 = 18'sd16055;
            4'd3:    atan_q16 = 18'sd8150;
            4'd4:    atan_q16 = 18'sd4091;
            4'd5:    atan_q16 = 18'sd2047;
            4'd6:    atan_q16 = 18'sd1024;
            4'd7:    atan_q16 = 18'sd512;
            4'd8:    atan_q16 = 18'sd256;
            4'd9:    atan_q16 = 18'sd128;
            4'd10:   atan_q16 = 18'sd64;
            4'd11:   atan_q16 = 18'sd32;
            4'd12:   atan_q16 = 18'sd16;
            4'd13:   atan_q16 = 18'sd8;
            4'd14:   atan_q16 = 18'sd4;
            default: atan_q16 = 18'sd2;
        endcase
    endfunction

endpackage

// ----- sv/rcep_ctrl.sv -----
module rcep_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cfg_we,
    input  rcep_pkg::stat_t stat,
    output logic          busy,
    output logic          done,
    output rcep_pkg::ctl_t  ctl
);
    import rcep_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_COR, S_ROD, S_QRY
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       rvalid_reg, rvalid_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rvalid_next = rvalid_reg;
        done_next   = 1'b0;
        ctl         = '0;
        ctl.count   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.mode == MODE_LOAD)
                begin
                    ctl.load_step = 1'b1;
                    cnt_next      = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd3)
                        state_next = S_IDLE;
                end
                else if (!rvalid_reg)
                begin
                    ctl.cordic_init = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_COR;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_QRY;
                end
            end
            S_COR:
            begin
                ctl.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    cnt_next   = '0;
                    state_next = S_ROD;
                end
            end
            S_ROD:
            begin
                ctl.rod_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd20)
                begin
                    cnt_next    = '0;
                    rvalid_next = 1'b1;
                    state_next  = S_QRY;
                end
            end
            S_QRY:
            begin
                ctl.query_step = 1'b1;
                cnt_next       = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_we)
            rvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
endmodule

// ----- sv/rcep_datapath.sv -----
module rcep_datapath (
    input  logic                clk,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                rst_n,
    input  rcep_pkg::in_word_t  din,
    input  rcep_pkg::ctl_t      ctl,
    output rcep_pkg::stat_t     stat,
    output rcep_pkg::out_word_t dout
);
    import rcep_pkg::*;

    // Configuration registers.
    logic signed [31:0] mu_reg;
    logic signed [15:0] theta_reg;
    logic signed [17:0] cv_reg [3];
    logic signed [17:0] ax_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= '0;
            theta_reg <= '0;
            cv_reg[0] <= '0;
            cv_reg[1] <= '0;
            cv_reg[2] <= 18'sd65536;
            ax_reg[0] <= 18'sd65536;
            ax_reg[1] <= '0;
            ax_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MU:    mu_reg    <= cfg_data;
                REG_THETA: theta_reg <= cfg_data[15:0];
                REG_CX:    cv_reg[0] <= cfg_data[17:0];
                REG_CY:    cv_reg[1] <= cfg_data[17:0];
                REG_CZ:    cv_reg[2] <= cfg_data[17:0];
                REG_AX:    ax_reg[0] <= cfg_data[17:0];
                REG_AY:    ax_reg[1] <= cfg_data[17:0];
                REG_AZ:    ax_reg[2] <= cfg_data[17:0];
                default:   mu_reg    <= mu_reg;
            endcase
        end
    end

    in_word_t in_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
            in_reg <= din;
    end
    assign stat.mode = in_reg.mode;

    // Edge load: the three cross components share one multiplier pair over steps.
    logic signed [47:0] mem_x [EdgeCount];
    logic signed [47:0] mem_y [EdgeCount];
    logic signed [47:0] mem_z [EdgeCount];
    logic signed [63:0] lp1_reg, lp2_reg;
    logic signed [31:0] la1, lb1, la2, lb2;
    logic signed [64:0] cdiff;
    logic signed [47:0] cres;

    always_comb
    begin
        case (ctl.count[1:0])
            2'd0:
            begin
                la1 = in_reg.first_node_y; lb1 = in_reg.second_node_z;
                la2 = in_reg.first_node_z; lb2 = in_reg.second_node_y;
            end
            2'd1:
            begin
                la1 = in_reg.first_node_z; lb1 = in_reg.second_node_x;
                la2 = in_reg.first_node_x; lb2 = in_reg.second_node_z;
            end
            default:
            begin
                la1 = in_reg.first_node_x; lb1 = in_reg.second_node_y;
                la2 = in_reg.first_node_y; lb2 = in_reg.second_node_x;
            end
        endcase
        cdiff = 65'(lp1_reg) - 65'(lp2_reg) + 65'sd65536;
        cres  = cdiff[64:17];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_step)
        begin
            lp1_reg <= la1 * lb1;
            lp2_reg <= la2 * lb2;
            if (ctl.count != 5'd0)
            begin
                case (ctl.count[1:0])
                    2'd1:    mem_x[in_reg.edge_index] <= cres;
                    2'd2:    mem_y[in_reg.edge_index] <= cres;
                    default: mem_z[in_reg.edge_index] <= cres;
                endcase
            end
        end
    end

    // CORDIC, one iteration per cycle.
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [20:0] cz_reg;
    logic               flip_reg;
    logic signed [21:0] t0, t1;
    logic               fl0;

    always_comb
    begin
        t0 = 22'(theta_reg) <<< 4;
        // Range of theta*16 is within about 1.3 turns, so two corrections suffice.
        if (t0 > 22'sd205887) t0 = t0 - 22'sd411775;
        if (t0 > 22'sd205887) t0 = t0 - 22'sd411775;
        if (t0 < -22'sd205887) t0 = t0 + 22'sd411775;
        if (t0 < -22'sd205887) t0 = t0 + 22'sd411775;
        fl0 = 1'b0;
        t1  = t0;
        if (t0 > 22'sd102944)
        begin
            t1 = t0 - 22'sd205887; fl0 = 1'b1;
        end
        else if (t0 < -22'sd102944)
        begin
            t1 = t0 + 22'sd205887; fl0 = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cordic_init)
        begin
            cx_reg   <= 34'sd652032874;
            cy_reg   <= '0;
            cz_reg   <= t1[20:0];
            flip_reg <= fl0;
        end
        else if (ctl.cordic_step)
        begin
            if (!cz_reg[20])
            begin
                cx_reg <= cx_reg - (cy_reg >>> ctl.count[3:0]);
                cy_reg <= cy_reg + (cx_reg >>> ctl.count[3:0]);
                cz_reg <= cz_reg - 21'(atan_q16(ctl.count[3:0]));
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> ctl.count[3:0]);
                cy_reg <= cy_reg - (cx_reg >>> ctl.count[3:0]);
                cz_reg <= cz_reg + 21'(atan_q16(ctl.count[3:0]));
            end
        end
    end

    logic signed [33:0] cr_t, sr_t;
    logic signed [19:0] cs, sn;
    always_comb
    begin
        cr_t = (cx_reg + 34'sd8192) >>> 14;
        sr_t = (cy_reg + 34'sd8192) >>> 14;
        cs   = flip_reg ? -cr_t[19:0] : cr_t[19:0];
        sn   = flip_reg ? -sr_t[19:0] : sr_t[19:0];
    end

    // Rodrigues: step 0..2 cross/dot terms, then per component and vector
    // one product per cycle into an accumulator.
    logic signed [36:0] crs_reg [3];
    logic signed [20:0] w_reg;
    logic signed [37:0] dotacc_reg;
    logic signed [19:0] rc_reg [3];
    logic signed [19:0] rr_reg [3];
    logic signed [71:0] sacc_reg;
    logic signed [40:0] cw_reg;
    logic signed [37:0] pa, pb;
    logic [1:0]         kk, k1, k2;
    logic [4:0]         rs;
    logic [3:0]         sub;
    logic [1:0]         term;
    logic signed [20:0] ca, cb, cc;
    logic signed [40:0] cw;
    logic signed [40:0] m_ab;
    logic signed [17:0] m_v;
    logic signed [71:0] prod;
    logic signed [71:0] rsum;
    logic signed [39:0] rsh;
    logic signed [19:0] rclamp;

    always_comb
    begin
        kk = ctl.count[1:0];
        k1 = (kk == 2'd0) ? 2'd1 : ((kk == 2'd1) ? 2'd2 : 2'd0);
        k2 = (kk == 2'd0) ? 2'd2 : ((kk == 2'd1) ? 2'd0 : 2'd1);
        pa = 38'(ax_reg[k1] * cv_reg[k2]);
        pb = 38'(ax_reg[k2] * cv_reg[k1]);
        rs = ctl.count - 5'd3;
        // rs runs 0..17: nine steps for the rotation, then nine for its
        // derivative, each as three terms for each of the three components.
        if (rs < 5'd9)
        begin
            ca = 21'(cs); cb = 21'(sn); cc = 21'sd65536 - 21'(cs);
        end
        else
        begin
            ca = -21'(sn); cb = 21'(cs); cc = 21'(sn);
        end
        cw  = 41'(cc) * 41'(w_reg);
        sub = (rs < 5'd9) ? rs[3:0] : 4'(rs - 5'd9);
        case (sub)
            4'd0, 4'd1, 4'd2: kk = 2'd0;
            4'd3, 4'd4, 4'd5: kk = 2'd1;
            default:          kk = 2'd2;
        endcase
        case (sub)
            4'd0, 4'd3, 4'd6: term = 2'd0;
            4'd1, 4'd4, 4'd7: term = 2'd1;
            default:          term = 2'd2;
        endcase
        case (term)
            2'd0:    begin m_ab = 41'(ca); m_v = cv_reg[kk]; end
            2'd1:    begin m_ab = 41'(cb); m_v = 18'sd1; end
            default: begin m_ab = cw_reg; m_v = ax_reg[kk]; end
        endcase
        if (term == 2'd1)
            prod = 72'(cb) * 72'(crs_reg[kk]);
        else if (term == 2'd0)
            prod = (72'(m_ab) * 72'(m_v)) <<< 16;
        else
            prod = 72'(m_ab) * 72'(m_v);
        rsum   = sacc_reg + prod + 72'sd2147483648;
        rsh    = rsum[71:32];
        rclamp = (rsh > 40'sd524287) ? 20'sd524287 :
                 ((rsh < -40'sd524288) ? -20'sd524288 : rsh[19:0]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rod_step)
        begin
            // The weight of the axis term is registered in the step before its use.
            cw_reg <= cw;
            if (ctl.count < 5'd3)
            begin
                crs_reg[ctl.count[1:0]] <= 37'(pa - pb);
                if (ctl.count == 5'd0)
                    dotacc_reg <= 38'(ax_reg[0] * cv_reg[0]) + 38'(ax_reg[1] * cv_reg[1])
                                  + 38'(ax_reg[2] * cv_reg[2]);
                if (ctl.count == 5'd1)
                    w_reg <= dotacc_reg[36:16];
                sacc_reg <= '0;
            end
            else if (term == 2'd2)
            begin
                sacc_reg <= '0;
                if (rs < 5'd9)
                    rc_reg[kk] <= rclamp;
                else
                    rr_reg[kk] <= rclamp;
            end
            else
                sacc_reg <= sacc_reg + prod;
        end
    end

    // Query: read three components, accumulate hi/lo dot, then scale by mu (unscaled in MODE_DMU), saturating.
    logic signed [47:0] e_reg [3];
    logic signed [19:0] rv;
    logic signed [52:0] hi_reg;
    logic signed [37:0] lo_reg;
    logic signed [63:0] d_reg;
    logic [63:0]        am_reg;
    logic [31:0]        mm_reg;
    logic               neg_reg;
    logic [63:0]        phi_reg, plo_reg;
    logic [1:0]         qk;
    logic signed [47:0] ecur;
    logic signed [31:0] eh;
    logic [15:0]        el;

    always_comb
    begin
        qk   = ctl.count[1:0] - 2'd1;
        rv   = (in_reg.mode == MODE_DTH) ? rr_reg[qk] : rc_reg[qk];
        ecur = e_reg[qk];
        eh   = ecur[47:16];
        el   = ecur[15:0];
    end

    logic signed [63:0] dval;
    logic [63:0]        mag;
    logic               sat;
    logic signed [47:0] outv;
    always_comb
    begin
        dval = 64'(hi_reg) + 64'((lo_reg + 38'sd32768) >>> 16);
        mag  = (phi_reg << 16) + ((plo_reg + 64'd32768) >> 16);
        sat  = 1'b0;
        if (in_reg.mode == MODE_DMU)
        begin
            if (d_reg > 64'sd140737488355327)
            begin
                sat = 1'b1; outv = 48'sh7FFFFFFFFFFF;
            end
            else if (d_reg < -64'sd140737488355328)
            begin
                sat = 1'b1; outv = 48'sh800000000000;
            end
            else
                outv = d_reg[47:0];
        end
        else if (phi_reg[63:32] != 32'd0 ||
                 mag > (neg_reg ? 64'd140737488355328 : 64'd140737488355327))
        begin
            sat  = 1'b1;
            outv = neg_reg ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
        end
        else
        begin
            outv = neg_reg ? -mag[47:0] : mag[47:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.query_step)
        begin
            case (ctl.count[2:0])
                3'd0:
                begin
                    e_reg[0] <= mem_x[in_reg.edge_index];
                    e_reg[1] <= mem_y[in_reg.edge_index];
                    e_reg[2] <= mem_z[in_reg.edge_index];
                    hi_reg   <= '0;
                    lo_reg   <= '0;
                end
                3'd1, 3'd2, 3'd3:
                begin
                    hi_reg <= hi_reg + 53'(rv * eh);
                    lo_reg <= lo_reg + 38'(rv * $signed({1'b0, el}));
                end
                3'd4:
                begin
                    d_reg   <= dval;
                    neg_reg <= mu_reg[31] != dval[63];
                    mm_reg  <= mu_reg[31] ? 32'(-64'(mu_reg)) : mu_reg;
                    am_reg  <= dval[63] ? -dval : dval;
                end
                3'd5:
                begin
                    phi_reg <= 64'(mm_reg) * 64'(am_reg[63:32]);
                    plo_reg <= 64'(mm_reg) * 64'(am_reg[31:0]);
                end
                3'd6:
                begin
                    dout.projection_value <= outv;
                    dout.saturated        <= sat;
                end
                default: hi_reg <= hi_reg;
            endcase
        end
    end
endmodule

// ----- sv/rotated_curl_edge_projection.sv -----
// Edge projection with a rotated constant curl. A load (mode 0) gives no
// word; a query first reruns the 16-step CORDIC and the 21-step Rodrigues
// sequence when it is the first after reset or after a configuration write.
// busy is high throughout; the result word is valid while done is high, for
// one cycle, and cannot be held off by the receiver.
module rotated_curl_edge_projection (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rcep_pkg::in_word_t  in_word,
    output logic                done,
    output rcep_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import rcep_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    rcep_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cfg_we(cfg_we),
        .stat(stat), .busy(busy), .done(done), .ctl(ctl)
    );

    rcep_datapath u_dp (
        .clk(clk), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .rst_n(rst_n), .din(in_word), .ctl(ctl), .stat(stat), .dout(out_word)
    );

`include "rotated_curl_edge_projection_assert.svh"

    `RCEP_ASSERT_IMPLY(a_done_busy, done, !busy)
    `RCEP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `RCEP_ASSERT_NEXT(a_done_single, done, !done)
endmodule
